@@ sv/fsf_pkg.sv @@
// fsf_pkg: shared widths, mode codes, command and box types, state enums
// for the shape fill engine; no dependencies
`default_nettype none
package fsf_pkg;

    localparam int FRAME_WIDTH_DEF  = 128;
    localparam int FRAME_HEIGHT_DEF = 128;

    localparam int MODE_W   = 3;
    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 11;
    localparam int THICK_W  = 10;
    localparam int COLOR_W  = 24;

    // signed width for unclipped box arithmetic, pixel deltas and squared sums
    localparam int CALC_W  = 14;
    localparam int DELTA_W = 14;
    localparam int SQ_W    = 27;

    localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL_ALL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RECT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DISC     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OUT_IN   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_OUT_OUT  = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
        logic [RADIUS_W-1:0]       radius;
        logic [THICK_W-1:0]        thickness;
        logic [COLOR_W-1:0]        color;
    } t_cmd;

    typedef struct packed {
        logic signed [CALC_W-1:0] x0;
        logic signed [CALC_W-1:0] y0;
        logic signed [CALC_W-1:0] x1;
        logic signed [CALC_W-1:0] y1;
    } t_box;

    typedef struct packed {
        logic start;
        logic disc;
    } t_rast_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_PIX,
        ST_READ,
        ST_BOX,
        ST_RUN,
        ST_DONE
    } t_ctl_state;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_SETUP,
        RS_SCAN
    } t_rast_state;

endpackage
`default_nettype wire

@@ sv/fsf_cmd_if.sv @@
// fsf_cmd_if: valid/ready command channel of the shape fill engine
// depends on fsf_pkg for field widths
`default_nettype none
interface fsf_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [fsf_pkg::MODE_W-1:0]            mode;
    logic signed [fsf_pkg::COORD_W-1:0]    x_first;
    logic signed [fsf_pkg::COORD_W-1:0]    y_first;
    logic signed [fsf_pkg::COORD_W-1:0]    x_second;
    logic signed [fsf_pkg::COORD_W-1:0]    y_second;
    logic [fsf_pkg::RADIUS_W-1:0]          radius;
    logic [fsf_pkg::THICK_W-1:0]           thickness;
    logic [fsf_pkg::COLOR_W-1:0]           color;

    modport source (
        output valid, mode, x_first, y_first, x_second, y_second, radius, thickness, color,
        input  ready
    );
    modport sink (
        input  valid, mode, x_first, y_first, x_second, y_second, radius, thickness, color,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/fsf_rsp_if.sv @@
// fsf_rsp_if: valid/ready result channel of the shape fill engine
// depends on fsf_pkg for field widths
`default_nettype none
interface fsf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fsf_pkg::COLOR_W-1:0]  read_color;
    logic                         read_inside;

    modport source (
        output valid, read_color, read_inside,
        input  ready
    );
    modport sink (
        input  valid, read_color, read_inside,
        output ready
    );
endinterface
`default_nettype wire

@@ sv/framebuffer_shape_fill_engine.sv @@
// framebuffer_shape_fill_engine: top level, command sequencer, frame store
// and result register; uses fsf_pkg, fsf_cmd_if, fsf_rsp_if, fsf_ram, fsf_raster
//
//  channel  | dir | transfer holds
//  ---------+-----+-----------------------------------------------------------
//  i_cmd    | in  | mode, x/y first, x/y second, radius, thickness, color
//  o_rsp    | out | read_color, read_inside
//
// after reset the frame store is swept to zero, with i_cmd.ready low. one
// command at a time: a read, a pixel set or a drawing (outlines take four
// boxes), with all writes through the single write port of the frame store.
// a new command is taken while the previous result waits in o_rsp; the
// engine stalls only before loading o_rsp.
`default_nettype none
module framebuffer_shape_fill_engine #(
    parameter int FRAME_WIDTH  = fsf_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fsf_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsf_cmd_if.sink    i_cmd,
    fsf_rsp_if.source  o_rsp
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XI    = $clog2(FRAME_WIDTH);
    localparam int YI    = $clog2(FRAME_HEIGHT);
    localparam int CW    = fsf_pkg::CALC_W;
    localparam int COLW  = fsf_pkg::COLOR_W;
    localparam logic signed [CW-1:0] W_S = CW'(FRAME_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(FRAME_HEIGHT);

    fsf_pkg::t_ctl_state r_state, n_state;

    fsf_pkg::t_cmd     r_cmd;
    fsf_pkg::t_box     r_rect;
    logic signed [CW-1:0] r_thick;
    logic [1:0]        r_seg, r_last_seg;
    logic [AW-1:0]     r_clr, r_pix_addr;
    logic              r_inside;
    logic [COLW-1:0]   r_rc;
    logic              r_ri;
    logic              r_out_valid;
    logic [COLW-1:0]   r_out_color;
    logic              r_out_inside;

    logic              w_accept, w_load_out;
    logic              w_is_pix, w_is_draw, w_in_frame;
    logic signed [CW-1:0] w_xa, w_ya, w_xb, w_yb, w_r, w_t;
    logic [AW-1:0]     w_pix_addr;
    fsf_pkg::t_box     w_rect, w_box;

    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr;
    logic [COLW-1:0]   w_wdata, w_rdata;

    fsf_pkg::t_rast_cmd w_rast_cmd;
    logic              w_rast_we, w_rast_done;
    logic [AW-1:0]     w_rast_addr;

    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == fsf_pkg::ST_IDLE);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_color  = r_out_color;
    assign o_rsp.read_inside = r_out_inside;

    // command decode and base rectangle
    assign w_xa = CW'(r_cmd.x_first);
    assign w_ya = CW'(r_cmd.y_first);
    assign w_xb = CW'(r_cmd.x_second);
    assign w_yb = CW'(r_cmd.y_second);
    assign w_r  = CW'(r_cmd.radius);
    assign w_t  = CW'(r_cmd.thickness);

    assign w_is_pix   = (r_cmd.mode == fsf_pkg::MODE_READ) || (r_cmd.mode == fsf_pkg::MODE_SET);
    assign w_is_draw  = (r_cmd.mode == fsf_pkg::MODE_FILL_ALL) ||
                        (r_cmd.mode == fsf_pkg::MODE_RECT) ||
                        (r_cmd.mode == fsf_pkg::MODE_DISC) ||
                        (r_cmd.mode == fsf_pkg::MODE_OUT_IN) ||
                        (r_cmd.mode == fsf_pkg::MODE_OUT_OUT);
    assign w_in_frame = (w_xa >= 0) && (w_ya >= 0) && (w_xa < W_S) && (w_ya < H_S);
    assign w_pix_addr = AW'(r_cmd.y_first[YI-1:0]) * AW'(FRAME_WIDTH)
                      + AW'(r_cmd.x_first[XI-1:0]);

    always_comb begin
        case (r_cmd.mode)
            fsf_pkg::MODE_FILL_ALL: begin
                w_rect = '{x0: '0, y0: '0, x1: W_S, y1: H_S};
            end
            fsf_pkg::MODE_DISC: begin
                w_rect = '{x0: w_xa - w_r + CW'(1), y0: w_ya - w_r + CW'(1),
                           x1: w_xa + w_r,          y1: w_ya + w_r};
            end
            fsf_pkg::MODE_OUT_OUT: begin
                w_rect = '{x0: w_xa - w_t, y0: w_ya - w_t, x1: w_xb + w_t, y1: w_yb + w_t};
            end
            default: begin
                w_rect = '{x0: w_xa, y0: w_ya, x1: w_xb, y1: w_yb};
            end
        endcase
    end

    // outline bands: top, left, right, bottom; the whole rectangle for the other shapes
    always_comb begin
        case (r_seg)
            2'd0: begin
                w_box = '{x0: r_rect.x0, y0: r_rect.y0,
                          x1: r_rect.x1, y1: r_rect.y0 + r_thick};
            end
            2'd1: begin
                w_box = '{x0: r_rect.x0, y0: r_rect.y0 + r_thick,
                          x1: r_rect.x0 + r_thick, y1: r_rect.y1};
            end
            2'd2: begin
                w_box = '{x0: r_rect.x1 - r_thick, y0: r_rect.y0 + r_thick,
                          x1: r_rect.x1, y1: r_rect.y1};
            end
            default: begin
                w_box = '{x0: r_rect.x0 + r_thick, y0: r_rect.y1 - r_thick,
                          x1: r_rect.x1 - r_thick, y1: r_rect.y1};
            end
        endcase
        if (r_last_seg == 2'd0) begin
            w_box = r_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_we       = 1'b0;
        w_waddr    = r_pix_addr;
        w_wdata    = r_cmd.color;
        w_re       = 1'b0;
        w_rast_cmd = '{start: 1'b0, disc: (r_cmd.mode == fsf_pkg::MODE_DISC)};
        w_load_out = 1'b0;
        unique case (r_state)
            fsf_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = fsf_pkg::ST_IDLE;
                end
            end
            fsf_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = fsf_pkg::ST_ADDR;
                end
            end
            fsf_pkg::ST_ADDR: begin
                if (w_is_pix) begin
                    n_state = fsf_pkg::ST_PIX;
                end else if (w_is_draw) begin
                    n_state = fsf_pkg::ST_BOX;
                end else begin
                    n_state = fsf_pkg::ST_DONE;
                end
            end
            fsf_pkg::ST_PIX: begin
                n_state = fsf_pkg::ST_DONE;
                if (r_inside) begin
                    if (r_cmd.mode == fsf_pkg::MODE_READ) begin
                        w_re    = 1'b1;
                        n_state = fsf_pkg::ST_READ;
                    end else begin
                        w_we = 1'b1;
                    end
                end
            end
            fsf_pkg::ST_READ: begin
                n_state = fsf_pkg::ST_DONE;
            end
            fsf_pkg::ST_BOX: begin
                w_rast_cmd.start = 1'b1;
                n_state = fsf_pkg::ST_RUN;
            end
            fsf_pkg::ST_RUN: begin
                w_we    = w_rast_we;
                w_waddr = w_rast_addr;
                if (w_rast_done) begin
                    n_state = (r_seg == r_last_seg) ? fsf_pkg::ST_DONE : fsf_pkg::ST_BOX;
                end
            end
            fsf_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state    = fsf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == fsf_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= '{mode: i_cmd.mode, x_first: i_cmd.x_first, y_first: i_cmd.y_first,
                       x_second: i_cmd.x_second, y_second: i_cmd.y_second,
                       radius: i_cmd.radius, thickness: i_cmd.thickness,
                       color: i_cmd.color};
            r_rc  <= '0;
            r_ri  <= 1'b0;
        end
        if (r_state == fsf_pkg::ST_ADDR) begin
            r_inside   <= w_in_frame;
            r_ri       <= w_in_frame && w_is_pix;
            r_pix_addr <= w_pix_addr;
            r_rect     <= w_rect;
            r_thick    <= w_t;
            r_seg      <= 2'd0;
            r_last_seg <= ((r_cmd.mode == fsf_pkg::MODE_OUT_IN) ||
                           (r_cmd.mode == fsf_pkg::MODE_OUT_OUT)) ? 2'd3 : 2'd0;
        end
        if (r_state == fsf_pkg::ST_READ) begin
            r_rc <= w_rdata;
        end
        if ((r_state == fsf_pkg::ST_RUN) && w_rast_done) begin
            r_seg <= r_seg + 2'd1;
        end
        if (w_load_out) begin
            r_out_color  <= r_rc;
            r_out_inside <= r_ri;
        end
    end

    fsf_ram #(
        .WIDTH (COLW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_pix_addr),
        .o_rdata (w_rdata)
    );

    fsf_raster #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    ) u_raster (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_rast_cmd),
        .i_box    (w_box),
        .i_cx     (r_cmd.x_first),
        .i_cy     (r_cmd.y_first),
        .i_radius (r_cmd.radius),
        .o_we     (w_rast_we),
        .o_addr   (w_rast_addr),
        .o_done   (w_rast_done)
    );

endmodule
`default_nettype wire

@@ sv/fsf_ram.sv @@
// fsf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module fsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/fsf_raster.sv @@
// fsf_raster: clips one half-open box to the frame and scans it one pixel per
// cycle, with an optional disc test kept by incremental squares; uses fsf_pkg
`default_nettype none
module fsf_raster #(
    parameter int FRAME_WIDTH  = fsf_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fsf_pkg::FRAME_HEIGHT_DEF,
    parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire fsf_pkg::t_rast_cmd                     i_cmd,
    input  wire fsf_pkg::t_box                          i_box,
    input  wire logic signed [fsf_pkg::COORD_W-1:0]     i_cx,
    input  wire logic signed [fsf_pkg::COORD_W-1:0]     i_cy,
    input  wire logic [fsf_pkg::RADIUS_W-1:0]           i_radius,
    output logic                                        o_we,
    output logic [AW-1:0]                               o_addr,
    output logic                                        o_done
);

    localparam int CW  = fsf_pkg::CALC_W;
    localparam int DW  = fsf_pkg::DELTA_W;
    localparam int SQW = fsf_pkg::SQ_W;
    localparam int RW  = fsf_pkg::RADIUS_W;
    localparam int XC  = $clog2(FRAME_WIDTH + 1);
    localparam int YC  = $clog2(FRAME_HEIGHT + 1);
    localparam logic signed [CW-1:0] W_S = CW'(FRAME_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(FRAME_HEIGHT);

    fsf_pkg::t_rast_state r_state, n_state;

    logic [XC-1:0]               r_x0, r_x1, r_x;
    logic [YC-1:0]               r_y1, r_y;
    logic                        r_empty, r_disc;
    logic signed [DW-1:0]        r_cx, r_cy;
    logic [RW-1:0]               r_radius;
    logic [AW-1:0]               r_row_base;
    logic signed [DW-1:0]        r_dx, r_dx_start, r_dy;
    logic signed [SQW-1:0]       r_dx2, r_dx2_start, r_dy2, r_r2;

    logic signed [CW-1:0]        w_x0c, w_y0c, w_x1c, w_y1c;
    logic signed [DW-1:0]        w_dx0, w_dy0;
    logic signed [2*DW-1:0]      w_dx0_sq, w_dy0_sq;
    logic [2*RW-1:0]             w_r_sq;
    logic [AW-1:0]               w_row_base;
    logic signed [SQW-1:0]       w_sum;
    logic                        w_x_last, w_y_last;

    // clip against the frame
    assign w_x0c = (i_box.x0 < 0)   ? '0  : i_box.x0;
    assign w_y0c = (i_box.y0 < 0)   ? '0  : i_box.y0;
    assign w_x1c = (i_box.x1 > W_S) ? W_S : i_box.x1;
    assign w_y1c = (i_box.y1 > H_S) ? H_S : i_box.y1;

    // setup arithmetic
    assign w_dx0      = $signed({{(DW-XC){1'b0}}, r_x0}) - r_cx;
    assign w_dy0      = $signed({{(DW-YC){1'b0}}, r_y}) - r_cy;
    assign w_dx0_sq   = w_dx0 * w_dx0;
    assign w_dy0_sq   = w_dy0 * w_dy0;
    assign w_r_sq     = r_radius * r_radius;
    assign w_row_base = AW'(r_y) * AW'(FRAME_WIDTH);

    assign w_sum    = r_dx2 + r_dy2;
    assign w_x_last = (XC'(r_x + 1'b1) == r_x1);
    assign w_y_last = (YC'(r_y + 1'b1) == r_y1);
    assign o_addr   = r_row_base + AW'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsf_pkg::RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_we    = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            fsf_pkg::RS_IDLE: begin
                if (i_cmd.start) begin
                    n_state = fsf_pkg::RS_SETUP;
                end
            end
            fsf_pkg::RS_SETUP: begin
                if (r_empty) begin
                    o_done  = 1'b1;
                    n_state = fsf_pkg::RS_IDLE;
                end else begin
                    n_state = fsf_pkg::RS_SCAN;
                end
            end
            fsf_pkg::RS_SCAN: begin
                o_we = !r_disc || (w_sum <= r_r2);
                if (w_x_last && w_y_last) begin
                    o_done  = 1'b1;
                    n_state = fsf_pkg::RS_IDLE;
                end
            end
            default: begin
                n_state = fsf_pkg::RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fsf_pkg::RS_IDLE: begin
                if (i_cmd.start) begin
                    r_empty  <= (w_x0c >= w_x1c) || (w_y0c >= w_y1c);
                    r_x0     <= XC'(w_x0c);
                    r_x      <= XC'(w_x0c);
                    r_x1     <= XC'(w_x1c);
                    r_y      <= YC'(w_y0c);
                    r_y1     <= YC'(w_y1c);
                    r_disc   <= i_cmd.disc;
                    r_cx     <= DW'(i_cx);
                    r_cy     <= DW'(i_cy);
                    r_radius <= i_radius;
                end
            end
            fsf_pkg::RS_SETUP: begin
                r_row_base  <= w_row_base;
                r_dx        <= w_dx0;
                r_dx_start  <= w_dx0;
                r_dy        <= w_dy0;
                r_dx2       <= SQW'(w_dx0_sq);
                r_dx2_start <= SQW'(w_dx0_sq);
                r_dy2       <= SQW'(w_dy0_sq);
                r_r2        <= SQW'(w_r_sq);
            end
            fsf_pkg::RS_SCAN: begin
                if (w_x_last) begin
                    r_x   <= r_x0;
                    r_dx  <= r_dx_start;
                    r_dx2 <= r_dx2_start;
                    if (!w_y_last) begin
                        r_y        <= YC'(r_y + 1'b1);
                        r_row_base <= r_row_base + AW'(FRAME_WIDTH);
                        r_dy       <= r_dy + DW'(1);
                        r_dy2      <= r_dy2 + (SQW'(r_dy) <<< 1) + SQW'(1);
                    end
                end else begin
                    r_x   <= XC'(r_x + 1'b1);
                    r_dx  <= r_dx + DW'(1);
                    r_dx2 <= r_dx2 + (SQW'(r_dx) <<< 1) + SQW'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
